[hw/rtl/dfsc_pkg.sv]
// Package for the download frame signature check block.
// Holds the phase type, result record, codes and the signature step function.
// No dependencies; every other file of the block imports it.
package dfsc_pkg;

  // Field widths fixed by the interface.
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int SIG_W  = 16;
  localparam int LOC_W  = 11;

  // Defaults for the top-level parameters.
  localparam int SCAN_LIMIT_DEF    = 256;
  localparam int MAX_LOCATIONS_DEF = 1024;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_LOCATION_COUNT = 2'd0;
  localparam logic [LOC_W-1:0]      LOCATION_COUNT_RST  = 11'd1024;

  // Stream constants.
  localparam logic [BYTE_W-1:0] MARKER   = 8'h46;
  localparam logic [BYTE_W-1:0] SIG_INIT = 8'hAA;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DATA      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OK        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MISMATCH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NO_MARKER = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SKIP_A,
    PH_SKIP_B,
    PH_DATA,
    PH_CK_LOW,
    PH_CK_HIGH
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic [SIG_W-1:0]  signature;
  } result_t;

  // New first byte: first rotated left by one, plus second, plus data, mod 256.
  function automatic logic [BYTE_W-1:0] sig_first_step(logic [BYTE_W-1:0] first,
                                                      logic [BYTE_W-1:0] second,
                                                      logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] rot;
    rot = {first[BYTE_W-2:0], first[BYTE_W-1]};
    return rot + second + data;
  endfunction

endpackage

[hw/rtl/dfsc_if.sv]
// Valid/ready channel interfaces of the download frame signature check block.
// Depends on dfsc_pkg for the field widths.

interface dfsc_rx_if import dfsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfsc_res_if import dfsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] kind;
  logic [SIG_W-1:0]  signature;

  modport source (output valid, output out_byte, output kind, output signature,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input signature,
                  output ready);
endinterface

[hw/rtl/download_frame_signature_check_unit.sv]
// Top level of the download frame signature check block.
// Holds the APB register, the input stage and the result register around dfsc_frame.
// Depends on dfsc_pkg, dfsc_if (dfsc_rx_if, dfsc_res_if) and dfsc_frame.
//
//   Channel   Direction  Handshake            Carries
//   rx        in         valid/ready          rx_byte
//   result    out        valid/ready          out_byte, kind, signature
//   apb       in         psel/penable/pready  location_count register
//
// One byte is taken per cycle while the input register is empty or can move on.
// A byte waits in the input register, is worked on by the frame logic and lands
// in the result register once that register is free, and its result is offered
// from there until it is transferred.
// Reset (rst, synchronous) returns to the hunt phase with the count register at 1024.
// A stalled result only holds back the input stage when that stage is full too,
// so a byte is still taken while a finished result waits.
module download_frame_signature_check_unit
  import dfsc_pkg::*;
#(
  parameter int SCAN_LIMIT    = SCAN_LIMIT_DEF,
  parameter int MAX_LOCATIONS = MAX_LOCATIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dfsc_rx_if.sink               rx,
  dfsc_res_if.source            result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration register. Writes complete in the access cycle; only the
  // address of location_count is decoded, other addresses are ignored.
  logic [LOC_W-1:0] location_count;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LOCATION_COUNT) ? APB_DATA_W'(location_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      location_count <= LOCATION_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LOCATION_COUNT) begin
      location_count <= pwdata[LOC_W-1:0];
    end
  end

  // Input register. It moves on whenever the result register is free or is
  // being emptied in this cycle.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_free;
  logic              s1_fire;
  result_t           res;
  result_t           out_q;

  assign out_free = !out_q.valid || result.ready;
  assign s1_fire  = s1_valid && out_free;
  assign rx.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  // The frame logic updates its state once per byte leaving the input register.
  dfsc_frame #(
    .SCAN_LIMIT    (SCAN_LIMIT),
    .MAX_LOCATIONS (MAX_LOCATIONS)
  ) u_frame (
    .clk            (clk),
    .rst            (rst),
    .step           (s1_fire),
    .rx_byte        (s1_byte),
    .location_count (location_count),
    .res            (res)
  );

  // Result register. Bytes that give no result (hunt bytes short of a give-up, line
  // ends, low checksum byte) simply leave it empty. Only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_q.valid <= 1'b0;
    end else if (out_free) begin
      out_q.valid <= s1_fire && res.valid;
    end
    if (out_free) begin
      out_q.out_byte  <= res.out_byte;
      out_q.kind      <= res.kind;
      out_q.signature <= res.signature;
    end
  end

  assign result.valid     = out_q.valid;
  assign result.out_byte  = out_q.out_byte;
  assign result.kind      = out_q.kind;
  assign result.signature = out_q.signature;

endmodule

[hw/rtl/dfsc_frame.sv]
// Frame state machine: phase, counters and the running signature.
// Advances once per step and gives the result of that byte combinationally.
// Depends on dfsc_pkg.
module dfsc_frame
  import dfsc_pkg::*;
#(
  parameter int SCAN_LIMIT    = SCAN_LIMIT_DEF,
  parameter int MAX_LOCATIONS = MAX_LOCATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [LOC_W-1:0]  location_count,
  output result_t           res
);

  localparam int SC_W = $clog2(SCAN_LIMIT + 1);
  localparam int BC_W = $clog2(2 * MAX_LOCATIONS + 1);
  localparam int CW   = (BC_W > LOC_W) ? BC_W : LOC_W;

  phase_t            phase, phase_next;
  logic [SC_W-1:0]   scan_count, scan_count_next;
  logic [BC_W-1:0]   byte_count, byte_count_next;
  logic [BYTE_W-1:0] sig_first, sig_first_next;
  logic [BYTE_W-1:0] sig_second, sig_second_next;
  logic [BYTE_W-1:0] received_low, received_low_next;

  logic [CW-1:0] loc_sat;
  logic [CW:0]   frame_bytes;
  logic [CW:0]   count_inc;
  logic          scan_expired;
  logic          data_done;
  logic [SIG_W-1:0] sig_now;

  // The count register is read live and saturated to the largest frame.
  always_comb begin
    if (CW'(location_count) > CW'(MAX_LOCATIONS)) begin
      loc_sat = CW'(MAX_LOCATIONS);
    end else begin
      loc_sat = CW'(location_count);
    end
  end

  assign frame_bytes  = {loc_sat, 1'b0};
  assign count_inc    = (CW + 1)'(byte_count) + (CW + 1)'(1);
  assign data_done    = count_inc >= frame_bytes;
  assign scan_expired = scan_count >= SC_W'(SCAN_LIMIT);
  assign sig_now      = {sig_first, sig_second};

  // Next phase.
  always_comb begin
    unique case (phase)
      PH_SKIP_A:  phase_next = PH_SKIP_B;
      PH_SKIP_B:  phase_next = (frame_bytes == '0) ? PH_CK_LOW : PH_DATA;
      PH_DATA:    phase_next = data_done ? PH_CK_LOW : PH_DATA;
      PH_CK_LOW:  phase_next = PH_CK_HIGH;
      PH_CK_HIGH: phase_next = PH_HUNT;
      default:    phase_next = (rx_byte == MARKER) ? PH_SKIP_A : PH_HUNT;
    endcase
  end

  // Counters, signature and the result of this byte.
  always_comb begin
    scan_count_next   = scan_count;
    byte_count_next   = byte_count;
    sig_first_next    = sig_first;
    sig_second_next   = sig_second;
    received_low_next = received_low;
    res               = '0;
    unique case (phase)
      PH_SKIP_A, PH_SKIP_B: begin
      end
      PH_DATA: begin
        sig_second_next = sig_first;
        sig_first_next  = sig_first_step(sig_first, sig_second, rx_byte);
        byte_count_next = byte_count + BC_W'(1);
        res.valid       = 1'b1;
        res.out_byte    = rx_byte;
        res.kind        = KIND_DATA;
      end
      PH_CK_LOW: begin
        received_low_next = rx_byte;
      end
      PH_CK_HIGH: begin
        res.valid       = 1'b1;
        res.kind        = ({rx_byte, received_low} == sig_now) ? KIND_OK : KIND_MISMATCH;
        res.signature   = sig_now;
        scan_count_next = '0;
        byte_count_next = '0;
        sig_first_next  = SIG_INIT;
        sig_second_next = SIG_INIT;
      end
      default: begin
        if (rx_byte == MARKER) begin
          scan_count_next = '0;
          byte_count_next = '0;
          sig_first_next  = SIG_INIT;
          sig_second_next = SIG_INIT;
        end else if (scan_expired) begin
          scan_count_next = '0;
          res.valid       = 1'b1;
          res.kind        = KIND_NO_MARKER;
        end else begin
          scan_count_next = scan_count + SC_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      scan_count   <= '0;
      byte_count   <= '0;
      sig_first    <= SIG_INIT;
      sig_second   <= SIG_INIT;
      received_low <= '0;
    end else if (step) begin
      phase        <= phase_next;
      scan_count   <= scan_count_next;
      byte_count   <= byte_count_next;
      sig_first    <= sig_first_next;
      sig_second   <= sig_second_next;
      received_low <= received_low_next;
    end
  end

  // The hunt counter never passes its limit.
  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    scan_count <= SC_W'(SCAN_LIMIT))
    else $error("scan_count above limit");

  // A finished frame leaves the signature seeded for the next one.
  a_sig_reseed: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_CK_HIGH) |=>
      (phase == PH_HUNT && sig_first == SIG_INIT && sig_second == SIG_INIT
       && byte_count == '0))
    else $error("signature not reseeded after frame end");

  // A no-marker result only comes from the hunt phase with the counter at its limit.
  a_no_marker_src: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_NO_MARKER) |-> (phase == PH_HUNT && scan_expired))
    else $error("no-marker result outside hunt timeout");

  // A data byte either keeps the frame in the data phase or moves it on to the checksum.
  a_data_exit: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_DATA) |=> (phase == PH_DATA || phase == PH_CK_LOW))
    else $error("data phase left to an unexpected phase");

endmodule

[dv/tb.sv]
// Testbench for download_frame_signature_check_unit: directed and random byte streams.
// A built-in model of the frame logic predicts every result for an in-order check.
// Depends on dfsc_pkg, the dfsc_rx_if/dfsc_res_if interfaces and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfsc_pkg::*;

  localparam int SCAN_LIMIT      = SCAN_LIMIT_DEF;
  localparam int MAX_LOCS        = MAX_LOCATIONS_DEF;
  localparam int RANDOM_BYTES    = 100;     // per idling setting
  localparam int HOLD_OFF_CYCLES = 400;     // long receiver stall in the hold-off test
  localparam int SETTLE_CYCLES   = 6;       // lets bytes with no result clear the pipeline
  localparam int DRAIN_LIMIT     = 5000;    // longer than the hold-off stretch
  localparam int RUN_LIMIT       = 400000;  // many times the slowest correct run

  // One result transfer as the block should present it.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic [SIG_W-1:0]  signature;
  } stream_out_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dfsc_rx_if  rx_if ();
  dfsc_res_if res_if ();

  download_frame_signature_check_unit #(
    .SCAN_LIMIT    (SCAN_LIMIT),
    .MAX_LOCATIONS (MAX_LOCS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the frame logic. It advances once per accepted rx transfer, so
  // it always reflects the bytes the block has taken, not the bytes it has finished.
  logic [LOC_W-1:0]  cfg_locs = LOCATION_COUNT_RST;
  phase_t            ph       = PH_HUNT;
  int                scan_cnt = 0;
  int                data_cnt = 0;
  logic [SIG_W-1:0]  run_sig  = {SIG_INIT, SIG_INIT};
  logic [BYTE_W-1:0] ck_low   = '0;

  // Results owed by the block, oldest first.
  stream_out_t due_outputs[$];

  int fail_count     = 0;
  int useful_bytes   = 0;  // bytes that moved the frame logic along
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of data bytes in a frame under the current count, with saturation.
  function automatic int frame_len();
    return 2 * ((cfg_locs > MAX_LOCS) ? MAX_LOCS : int'(cfg_locs));
  endfunction

  // Signature update: the old first byte moves down to second, and the new first
  // byte is the old first rotated left by one plus the old second plus the data.
  function automatic logic [SIG_W-1:0] sig_after(logic [SIG_W-1:0] s, logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] hi;
    hi = s[SIG_W-1:BYTE_W];
    return {BYTE_W'({hi[BYTE_W-2:0], hi[BYTE_W-1]} + s[BYTE_W-1:0] + d), hi};
  endfunction

  // Advances the shadow frame logic by one byte. Returns 1 when the byte causes a
  // result, which is then left in r.
  function automatic bit follow_stream(input logic [BYTE_W-1:0] b, output stream_out_t r);
    r = '0;
    case (ph)
      PH_SKIP_A: ph = PH_SKIP_B;
      PH_SKIP_B: ph = (frame_len() == 0) ? PH_CK_LOW : PH_DATA;
      PH_DATA: begin
        run_sig = sig_after(run_sig, b);
        data_cnt++;
        // The count is read live, so a smaller value can end the data at once.
        if (data_cnt >= frame_len()) ph = PH_CK_LOW;
        r.out_byte = b;
        r.kind     = KIND_DATA;
        return 1'b1;
      end
      PH_CK_LOW: begin
        ck_low = b;
        ph     = PH_CK_HIGH;
      end
      PH_CK_HIGH: begin
        r.kind      = ({b, ck_low} == run_sig) ? KIND_OK : KIND_MISMATCH;
        r.signature = run_sig;
        ph          = PH_HUNT;
        scan_cnt    = 0;
        data_cnt    = 0;
        run_sig     = {SIG_INIT, SIG_INIT};
        return 1'b1;
      end
      default: begin
        if (b == MARKER) begin
          ph       = PH_SKIP_A;
          scan_cnt = 0;
          data_cnt = 0;
          run_sig  = {SIG_INIT, SIG_INIT};
        end else if (scan_cnt >= SCAN_LIMIT) begin
          // The hunt gives up on the byte after SCAN_LIMIT misses and starts over.
          scan_cnt = 0;
          r.kind   = KIND_NO_MARKER;
          return 1'b1;
        end else begin
          scan_cnt++;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    return (b == MARKER) ? ~b : b;
  endfunction

  // Offers one byte on rx, idling first at the current rate. Returns at the falling
  // edge after the transfer with valid still high, so back-to-back bytes never drop
  // valid in between.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    stream_out_t r;
    phase_t      prev;
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    prev = ph;
    if (follow_stream(b, r)) begin
      due_outputs.push_back(r);
      useful_bytes++;
    end else if (ph != prev) begin
      useful_bytes++;
    end
    @(negedge clk);
  endtask

  // Marker, two line-end bytes, the data and the checksum. The checksum comes from
  // the shadow signature; ck_err bit 0 corrupts its low byte and bit 1 its high byte.
  // fill and le fix the data and line-end values when not negative. A cut of zero or
  // more stops after that many data bytes and sends no checksum.
  task automatic send_frame(input int ck_err, input int fill = -1, input int le = -1,
                            input int cut = -1);
    int               n;
    int               i;
    logic [SIG_W-1:0] ck;
    n = frame_len();
    send_byte(MARKER);
    repeat (2) send_byte((le < 0) ? BYTE_W'($urandom) : BYTE_W'(le));
    for (i = 0; i < n; i++) begin
      if (i == cut) return;
      send_byte((fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill));
    end
    if (cut >= 0) return;
    ck = run_sig;
    if (ck_err[0]) ck[BYTE_W-1:0] ^= BYTE_W'(1 << $urandom_range(BYTE_W - 1));
    if (ck_err[1]) ck[SIG_W-1:BYTE_W] ^= BYTE_W'(1 << $urandom_range(BYTE_W - 1));
    send_byte(ck[BYTE_W-1:0]);
    send_byte(ck[SIG_W-1:BYTE_W]);
  endtask

  // Stops offering bytes and waits until every owed result has come out, then lets
  // bytes that cause no result get through the pipeline as well.
  task automatic wait_idle();
    int waited = 0;
    rx_if.valid <= 1'b0;
    while (due_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (due_outputs.size() != 0) begin
      $error("%0d results never came out of the block", due_outputs.size());
      fail_count++;
      due_outputs.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One APB transfer to the count register: setup phase, then access phase until
  // pready. A read is compared with the shadow copy of the register.
  task automatic reg_access(input bit wr, input logic [LOC_W-1:0] v);
    logic [APB_DATA_W-1:0] wdata;
    wdata              = APB_DATA_W'($urandom);
    wdata[LOC_W-1:0]   = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_LOCATION_COUNT;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      cfg_locs = v;
    end else if (prdata !== APB_DATA_W'(cfg_locs)) begin
      $error("location_count: expected %0d, actual %0d", cfg_locs, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The register is only written with the block idle; each write is read back.
  task automatic set_locations(input logic [LOC_W-1:0] v);
    wait_idle();
    reg_access(1'b1, v);
    reg_access(1'b0, '0);
  endtask

  // A frame starts at the reset count, which is the largest frame. Halfway through
  // the data the count is raised above the maximum; it must saturate, so the frame
  // still ends after the same number of data bytes.
  task automatic test_largest_frames();
    reg_access(1'b0, '0);
    send_frame(0, -1, -1, MAX_LOCS);
    set_locations(11'd2047);
    while (ph == PH_DATA) send_byte(BYTE_W'($urandom));
    send_byte(run_sig[BYTE_W-1:0]);
    send_byte(run_sig[SIG_W-1:BYTE_W]);
  endtask

  // One location with data at both extremes and every kind of checksum damage,
  // then a zero count, where the checksum follows the line-end bytes directly.
  task automatic test_short_frames();
    set_locations(11'd1);
    send_frame(0, 8'h00);
    send_frame(0, 8'hFF);
    send_frame(1, 8'hFF);
    send_frame(2);
    send_frame(3, 8'h00);
    set_locations(11'd0);
    send_frame(0);
    send_frame(2);
  endtask

  // Line-end bytes are dropped whatever they hold, the marker value included.
  task automatic test_line_end_bytes();
    set_locations(11'd1);
    send_frame(0, -1, MARKER);
    send_frame(0, -1, 8'h00);
    send_frame(0, -1, 8'hFF);
  endtask

  // One give-up, then a marker on the very last byte the hunt allows.
  task automatic test_hunt_give_up();
    send_byte(8'h00);
    send_byte(8'hFF);
    repeat (SCAN_LIMIT + 1 - 2) send_byte(noise_byte());
    repeat (SCAN_LIMIT) send_byte(noise_byte());
    send_frame(0);
  endtask

  // The count is changed in the middle of the data: shrunk below the bytes already
  // taken, grown past them, and set to zero. The frame then runs to the new end.
  task automatic test_live_count_change();
    int start_locs[3] = '{4, 2, 3};
    int taken[3]      = '{5, 1, 2};
    int new_locs[3]   = '{2, 3, 0};
    int k;
    for (k = 0; k < 3; k++) begin
      set_locations(LOC_W'(start_locs[k]));
      send_frame(0, -1, -1, taken[k]);
      set_locations(LOC_W'(new_locs[k]));
      while (ph == PH_DATA) send_byte(BYTE_W'($urandom));
      send_byte(run_sig[BYTE_W-1:0]);
      send_byte(run_sig[SIG_W-1:BYTE_W]);
    end
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so the
  // block fills up and has to stall its rx side.
  task automatic test_result_hold_off();
    set_locations(11'd8);
    hold_req = 1'b1;
    repeat (6) send_frame(0);
  endtask

  // Mostly well-formed frames with random content and small counts; the rest are
  // count changes, noise, truncated frames and now and then a hunt long enough to
  // give up.
  task automatic random_download_traffic(input int n_bytes);
    int stop_at;
    int pick;
    stop_at = useful_bytes + n_bytes;
    while (useful_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        repeat (SCAN_LIMIT + 1 + $urandom_range(20)) send_byte(noise_byte());
      end else if (pick < 8) begin
        set_locations(($urandom_range(3) != 0) ? LOC_W'($urandom_range(6))
                                               : LOC_W'($urandom_range(40, 7)));
      end else if (pick < 18) begin
        repeat ($urandom_range(12, 1)) send_byte(BYTE_W'($urandom));
      end else if (pick < 24) begin
        send_frame(0, -1, -1, $urandom_range(frame_len()));
      end else begin
        send_frame(($urandom_range(9) < 6) ? 0 : $urandom_range(3, 1));
      end
    end
  endtask

  // Result receiver. Ready changes at the falling edge; a requested hold-off is
  // counted down here at each falling edge, with ready held low.
  initial begin : result_receiver
    int hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every result transfer is matched, field by field, with the oldest owed result.
  always @(posedge clk) begin : result_checker
    stream_out_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (due_outputs.size() == 0) begin
        $error("result transfer with none owed: kind %0d, out_byte %0h, signature %0h",
               res_if.kind, res_if.out_byte, res_if.signature);
        fail_count++;
      end else begin
        want = due_outputs.pop_front();
        if (res_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, res_if.out_byte);
          fail_count++;
        end
        if (res_if.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, res_if.kind);
          fail_count++;
        end
        if (res_if.signature !== want.signature) begin
          $error("signature: expected %0h, actual %0h", want.signature, res_if.signature);
          fail_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin : run_watchdog
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin : test_sequence
    rst            = 1'b1;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct  = 9;
    recv_stall_pct = 73;
    test_largest_frames();
    test_short_frames();
    test_line_end_bytes();
    test_hunt_give_up();
    test_live_count_change();
    random_download_traffic(RANDOM_BYTES);

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct  = 73;
    recv_stall_pct = 9;
    random_download_traffic(RANDOM_BYTES);

    // Full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_result_hold_off();
    random_download_traffic(RANDOM_BYTES);

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
